[src/efsa_pkg.sv]
package efsa_pkg;

	// Server pool size and derived widths
	localparam int NUM_SERVERS = 8;
	localparam int SRV_W = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
	localparam int CNT_W = $clog2(NUM_SERVERS + 1);

	// Field widths
	localparam int ARR_W     = 20;
	localparam int SVC_W     = 16;
	localparam int FREE_W    = 24;
	localparam int SUM_W     = 32;
	localparam int TALLY_W   = 16;
	localparam int THR_W     = 16;
	localparam int ACT_W     = 4;
	localparam int SIDX_W    = 3;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	// Register reset values
	localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(8);
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(10);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_SERVERS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_THRESHOLD = 1'b1;

	typedef logic [FREE_W-1:0] free_t;
	typedef logic [SRV_W-1:0]  srv_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALC,
		ST_COMMIT
	} state_t;

endpackage

[src/earliest_free_server_assigner_unit.sv]
// Channel   Signals                               Direction  Moves
// item      item_valid/item_ready + 2 fields      in         one customer word
// result    result_valid/result_ready + 5 fields  out        one assignment word
// cfg       cfg_we, cfg_index, cfg_wdata          in         one register write
//
// The servers in use number active_servers clamped to 1..NUM_SERVERS: one shared
// 24-bit comparator walks the free times one server per cycle, then a wait step
// and a commit step. Reset clears every free time and both totals, and sets the
// registers to their defaults. A stalled result holds the commit step; the result
// register lets the block take the next word while a finished result waits.
module earliest_free_server_assigner_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  logic [efsa_pkg::ARR_W-1:0]      arrival_time,
	input  logic [efsa_pkg::SVC_W-1:0]      service_time,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [efsa_pkg::SIDX_W-1:0]     server_index,
	output logic [efsa_pkg::FREE_W-1:0]     wait_time,
	output logic                            long_wait,
	output logic [efsa_pkg::SUM_W-1:0]      total_wait,
	output logic [efsa_pkg::TALLY_W-1:0]    long_wait_count,
	input  logic                            cfg_we,
	input  logic [efsa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [efsa_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
	import efsa_pkg::*;

	// Configuration registers
	logic [ACT_W-1:0] active_q;
	logic [THR_W-1:0] thr_q;

	// Per-server free times; read at the scan address and, for the seed, at server 0
	free_t free_q [NUM_SERVERS];

	// Sequencer and working registers
	state_t state_q, state_d;
	cnt_t   idx_q;
	srv_t   best_idx_q;
	free_t  best_val_q;
	cnt_t   count_q;
	logic [ARR_W-1:0] arr_q;
	logic [SVC_W-1:0] svc_q;
	free_t  wait_q;
	free_t  start_q;

	// Running totals
	logic [SUM_W-1:0]   sum_q;
	logic [TALLY_W-1:0] tally_q;

	// Result register
	logic                result_valid_q;
	logic [SIDX_W-1:0]   srv_out_q;
	free_t               wait_out_q;
	logic                long_out_q;

	logic  accept;
	logic  out_free;
	logic  commit;
	cnt_t  count_use;
	free_t scan_val;
	logic [7:0] act_ext;

	logic [FREE_W:0]  next_free_wide;
	free_t            next_free;
	logic [SUM_W:0]   sum_wide;
	logic [SUM_W-1:0] sum_next;
	logic             is_long;
	logic [TALLY_W-1:0] tally_next;
	free_t            arr_ext;

	// Clamp the active count to 1..NUM_SERVERS
	always_comb begin
		act_ext = {{(8 - ACT_W){1'b0}}, active_q};
		if (act_ext == 8'd0) begin
			count_use = CNT_W'(1);
		end else if (act_ext > 8'(NUM_SERVERS)) begin
			count_use = CNT_W'(NUM_SERVERS);
		end else begin
			count_use = CNT_W'(act_ext);
		end
	end

	assign scan_val = free_q[idx_q[SRV_W-1:0]];
	assign out_free = !result_valid_q || result_ready;
	assign accept   = item_valid && item_ready;

	// Commit arithmetic: new free time, saturating totals, long-wait flag
	always_comb begin
		next_free_wide = {1'b0, start_q} + {{(FREE_W + 1 - SVC_W){1'b0}}, svc_q};
		next_free      = next_free_wide[FREE_W] ? {FREE_W{1'b1}} : next_free_wide[FREE_W-1:0];
		sum_wide       = {1'b0, sum_q} + {{(SUM_W + 1 - FREE_W){1'b0}}, wait_q};
		sum_next       = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
		is_long        = wait_q > {{(FREE_W - THR_W){1'b0}}, thr_q};
		tally_next     = (is_long && (tally_q != {TALLY_W{1'b1}})) ? tally_q + 1'b1 : tally_q;
	end

	assign arr_ext = {{(FREE_W - ARR_W){1'b0}}, arr_q};

	// Next state and handshake
	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		commit     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					state_d = (count_use == CNT_W'(1)) ? ST_CALC : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (idx_q == count_q - 1'b1) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (out_free) begin
					commit  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= ACT_RESET;
			thr_q    <= THR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ACTIVE_SERVERS: active_q <= cfg_wdata[ACT_W-1:0];
				REG_WAIT_THRESHOLD: thr_q    <= cfg_wdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Scan: capture the word, seed with server 0, then walk one server per cycle.
	// Strict less-than keeps the lowest index on a tie.
	always_ff @(posedge clk) begin
		if (accept) begin
			arr_q      <= arrival_time;
			svc_q      <= service_time;
			count_q    <= count_use;
			best_idx_q <= '0;
			best_val_q <= free_q[0];
			idx_q      <= CNT_W'(1);
		end else if (state_q == ST_SCAN) begin
			if (scan_val < best_val_q) begin
				best_idx_q <= idx_q[SRV_W-1:0];
				best_val_q <= scan_val;
			end
			idx_q <= idx_q + 1'b1;
		end
	end

	// Wait step: clamp at zero; service starts at the later of free and arrival
	always_ff @(posedge clk) begin
		if (state_q == ST_CALC) begin
			if (best_val_q > arr_ext) begin
				wait_q  <= best_val_q - arr_ext;
				start_q <= best_val_q;
			end else begin
				wait_q  <= '0;
				start_q <= arr_ext;
			end
		end
	end

	// Commit: update the chosen server, totals and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_SERVERS; k++) begin
				free_q[k] <= '0;
			end
			sum_q          <= '0;
			tally_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				free_q[best_idx_q] <= next_free;
				sum_q              <= sum_next;
				tally_q            <= tally_next;
				result_valid_q     <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			srv_out_q  <= SIDX_W'(best_idx_q);
			wait_out_q <= wait_q;
			long_out_q <= is_long;
		end
	end

	assign result_valid    = result_valid_q;
	assign server_index    = srv_out_q;
	assign wait_time       = wait_out_q;
	assign long_wait       = long_out_q;
	assign total_wait      = sum_q;
	assign long_wait_count = tally_q;

	// The scan index stays inside the servers in use
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> idx_q < count_q)
		else $error("scan index ran past the active servers");

	// The held minimum is the stored free time of the chosen server
	a_best_match: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CALC |-> best_val_q == free_q[best_idx_q])
		else $error("held minimum differs from the chosen server's free time");

	// The long-wait flag agrees with the threshold for the shown word
	a_long_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> long_out_q == (wait_out_q > {{(FREE_W - THR_W){1'b0}}, thr_q}))
		else $error("long-wait flag disagrees with the threshold");

	// Totals never go down at a commit
	a_sum_mono: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (sum_q >= $past(sum_q)) && (tally_q >= $past(tally_q)))
		else $error("running totals decreased");

endmodule

[tb/sv/tb_earliest_free_server_assigner_unit.sv]
module tb_earliest_free_server_assigner_unit;

	import efsa_pkg::*;

	// Cycles to let pass after the last result before a register write or the
	// end verdict: a full scan of the pool plus the wait and commit steps, with
	// slack for the result register.
	localparam int DRAIN_CYCLES = NUM_SERVERS + 8;
	localparam int ARR_MAX      = (1 << ARR_W) - 1;

	// One expected assignment word, field by field at the port widths.
	typedef struct packed {
		logic [SIDX_W-1:0]  server;
		logic [FREE_W-1:0]  waited;
		logic               long_flag;
		logic [SUM_W-1:0]   wait_total;
		logic [TALLY_W-1:0] long_total;
	} assignment_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 item_valid = 1'b0;
	logic                 item_ready;
	logic [ARR_W-1:0]     arrival_time = '0;
	logic [SVC_W-1:0]     service_time = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	logic [SIDX_W-1:0]    server_index;
	logic [FREE_W-1:0]    wait_time;
	logic                 long_wait;
	logic [SUM_W-1:0]     total_wait;
	logic [TALLY_W-1:0]   long_wait_count;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_wdata = '0;

	// Shadow of the block: per-server free times, both totals, both registers.
	logic [FREE_W-1:0]    srv_free_pred [NUM_SERVERS];
	logic [SUM_W-1:0]     wait_total_pred;
	logic [TALLY_W-1:0]   long_tally_pred;
	logic [ACT_W-1:0]     active_reg;
	logic [THR_W-1:0]     thresh_reg;

	assignment_t expected_assignments [$];

	int mismatches   = 0;
	int results_seen = 0;

	// Pacing knobs, flipped per test so some stretches run with no idling.
	bit tx_gaps_on   = 1'b1;
	bit rx_stalls_on = 1'b1;
	int burst_left   = 0;
	int rx_run_left  = 0;
	bit rx_ready_now = 1'b0;

	earliest_free_server_assigner_unit uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.arrival_time    (arrival_time),
		.service_time    (service_time),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.server_index    (server_index),
		.wait_time       (wait_time),
		.long_wait       (long_wait),
		.total_wait      (total_wait),
		.long_wait_count (long_wait_count),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Work out the assignment for one customer and advance the shadow state.
	// Scan the servers in use for the earliest free time (lowest index wins a
	// tie), clamp the wait at zero, saturate the new free time and both totals.
	function automatic assignment_t predict_assignment(input logic [ARR_W-1:0] arr,
			input logic [SVC_W-1:0] svc);
		int unsigned   in_use;
		int unsigned   best;
		int unsigned   k;
		logic [FREE_W-1:0] free_at;
		logic [FREE_W-1:0] waited;
		logic [FREE_W:0]   next_free;
		logic [SUM_W:0]    sum_wide;
		assignment_t   res;

		// A count of zero still leaves server 0 in use; anything past the pool
		// size means the whole pool.
		if (active_reg == 0)
			in_use = 1;
		else if (active_reg > NUM_SERVERS)
			in_use = NUM_SERVERS;
		else
			in_use = 32'(active_reg);

		best = 0;
		for (k = 1; k < in_use; k++)
			if (srv_free_pred[k] < srv_free_pred[best])
				best = k;

		free_at = srv_free_pred[best];
		waited  = (free_at > arr) ? free_at - arr : '0;
		// Service starts at the later of free time and arrival.
		next_free = ((free_at > arr) ? free_at : arr) + svc;
		srv_free_pred[best] = next_free[FREE_W] ? '1 : next_free[FREE_W-1:0];

		sum_wide = wait_total_pred + waited;
		wait_total_pred = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

		res.long_flag = waited > thresh_reg;
		if (res.long_flag && long_tally_pred != '1)
			long_tally_pred = long_tally_pred + 1'b1;

		res.server     = best[SIDX_W-1:0];
		res.waited     = waited;
		res.wait_total = wait_total_pred;
		res.long_total = long_tally_pred;
		return res;
	endfunction

	// Offer one customer word and hold it until the block takes it. Valid is
	// left high so a back-to-back word needs no second assignment this step.
	task automatic send_customer(input logic [ARR_W-1:0] arr, input logic [SVC_W-1:0] svc);
		item_valid   <= 1'b1;
		arrival_time <= arr;
		service_time <= svc;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		expected_assignments.push_back(predict_assignment(arr, svc));
	endtask

	// Bursts of random length with random gaps in between.
	task automatic pace_sender();
		if (tx_gaps_on) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				burst_left = $urandom_range(0, 24);
			end
		end
	endtask

	// Drop valid, wait out every outstanding result, then let the block settle.
	task automatic settle_block();
		item_valid <= 1'b0;
		while (expected_assignments.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ACTIVE_SERVERS)
			active_reg = data[ACT_W-1:0];
		else
			thresh_reg = data[THR_W-1:0];
		@(posedge clk);
	endtask

	// Reprogram both registers once the block is idle. Junk in the upper bits
	// of the server count must be ignored.
	task automatic configure(input logic [ACT_W-1:0] act, input logic [THR_W-1:0] thr);
		logic [CFG_DAT_W-1:0] act_word;

		settle_block();
		act_word = CFG_DAT_W'($urandom());
		act_word[ACT_W-1:0] = act;
		write_reg(REG_ACTIVE_SERVERS, act_word);
		write_reg(REG_WAIT_THRESHOLD, thr);
	endtask

	// With one server in use, aim a customer at an exact wait on server 0.
	task automatic send_with_wait(input logic [FREE_W-1:0] target, input logic [SVC_W-1:0] svc);
		logic [FREE_W-1:0] arr_wide;

		arr_wide = srv_free_pred[0] - target;
		send_customer(arr_wide[ARR_W-1:0], svc);
		pace_sender();
	endtask

	// Reset values: eight servers, threshold ten. Eight simultaneous arrivals
	// fill the pool in index order; the ninth waits on server 0.
	task automatic test_reset_defaults();
		int n;

		for (n = 0; n < 9; n++) begin
			send_customer('0, 16'd100);
			pace_sender();
		end
	endtask

	// Waits equal to the threshold are not long; one tick more is.
	task automatic test_wait_threshold();
		configure(4'd1, 16'd37);
		send_with_wait(24'd37, 16'd50);
		send_with_wait(24'd38, 16'd20);
		configure(4'd1, 16'd0);
		send_with_wait(24'd0, 16'd30);
		send_with_wait(24'd1, 16'd5);
		configure(4'd1, 16'hFFFF);
		send_with_wait(24'd200, 16'd0);
	endtask

	// Zero servers acts as one, counts past the pool act as the whole pool,
	// and idle servers keep their free times until the count is raised again.
	task automatic test_active_count();
		int n;

		configure(4'd0, 16'd10);
		for (n = 0; n < 2; n++) begin
			send_customer('0, 16'd10);
			pace_sender();
		end
		configure(4'd15, 16'd10);
		for (n = 0; n < 2; n++) begin
			send_customer('0, 16'd10);
			pace_sender();
		end
		configure(4'd9, 16'd10);
		send_customer(20'd5, 16'd10);
		pace_sender();
		configure(4'd1, 16'd10);
		send_customer(20'd7, 16'd3);
		pace_sender();
		configure(4'd8, 16'd10);
		send_customer(20'd9, 16'd3);
		pace_sender();
	endtask

	// Field extremes and an arrival that goes backwards in time.
	task automatic test_field_extremes();
		configure(4'd8, 16'd0);
		send_customer('1, '1);
		pace_sender();
		send_customer('0, '0);
		pace_sender();
		send_customer('1, '0);
		pace_sender();
		send_customer('0, '1);
		pace_sender();
		send_customer(20'd12345, 16'd777);
		pace_sender();
	endtask

	// Mostly ordered arrivals on a running clock with random service, so the
	// pool queues up; mixed with arrivals that step back, full-range noise and
	// field extremes. Each phase runs its own settings and pacing.
	task automatic test_random_traffic();
		logic [ACT_W-1:0] act_list [6];
		logic [THR_W-1:0] thr_list [6];
		int unsigned now_tick;
		int unsigned stride;
		int unsigned stride_max;
		int unsigned svc_max;
		int unsigned in_use;
		int unsigned pick;
		logic [ARR_W-1:0] arr;
		logic [SVC_W-1:0] svc;
		int ph;
		int n;

		act_list = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15, 4'd5};
		thr_list = '{16'd10, 16'd0, 16'hFFFF, 16'd50, 16'd5, 16'd0};
		act_list[5] = ACT_W'($urandom_range(0, 15));
		thr_list[5] = THR_W'($urandom_range(0, 400));
		now_tick = 0;

		for (ph = 0; ph < 6; ph++) begin
			configure(act_list[ph], thr_list[ph]);
			tx_gaps_on   = ($urandom_range(0, 3) != 0);
			rx_stalls_on = ($urandom_range(0, 3) != 0);
			in_use = (act_list[ph] == 0) ? 1 :
				(act_list[ph] > NUM_SERVERS) ? NUM_SERVERS : act_list[ph];
			svc_max    = $urandom_range(16, 600);
			stride_max = svc_max / in_use + $urandom_range(0, 20);

			for (n = 0; n < 210; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					stride = $urandom_range(0, stride_max);
					// Wrap the clock near the top of the field.
					if (now_tick + stride > ARR_MAX)
						now_tick = $urandom_range(0, 1000);
					else
						now_tick = now_tick + stride;
					arr = ARR_W'(now_tick);
					svc = SVC_W'($urandom_range(0, svc_max));
				end else if (pick < 88) begin
					// Step back a little behind the running clock.
					arr = (now_tick > 300) ? ARR_W'(now_tick - $urandom_range(1, 300)) : '0;
					svc = SVC_W'($urandom_range(0, svc_max));
				end else if (pick < 95) begin
					arr = ARR_W'($urandom());
					svc = SVC_W'($urandom());
				end else begin
					arr = pick[0] ? '1 : '0;
					svc = pick[1] ? '1 : '0;
				end
				send_customer(arr, svc);
				pace_sender();
			end
		end
	endtask

	// Pile work on one server: its free time saturates, the waits then sit at
	// the top of the field and the wait total saturates. Run flat out.
	task automatic test_total_saturation();
		int n;

		configure(4'd1, 16'd0);
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		for (n = 0; n < 520; n++)
			send_customer('0, '1);
	endtask

	task automatic check_field(input string fname, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			if (mismatches < 10)
				$display("result %0d %s: expected %0d, got %0d",
					results_seen, fname, want, got);
			mismatches++;
		end
	endtask

	// Check each accepted result word against the oldest expectation, then
	// advance the receiver's stall pattern: runs of ready and runs of stall.
	always @(posedge clk) begin : result_monitor
		assignment_t want;

		if (arst_n && result_valid && result_ready) begin
			if (expected_assignments.size() == 0) begin
				if (mismatches < 10)
					$display("result %0d arrived with no customer pending", results_seen);
				mismatches++;
			end else begin
				want = expected_assignments.pop_front();
				check_field("server_index", want.server, server_index);
				check_field("wait_time", want.waited, wait_time);
				check_field("long_wait", want.long_flag, long_wait);
				check_field("total_wait", want.wait_total, total_wait);
				check_field("long_wait_count", want.long_total, long_wait_count);
			end
			results_seen++;
		end

		if (!rx_stalls_on) begin
			rx_ready_now = 1'b1;
			rx_run_left  = 0;
			result_ready <= 1'b1;
		end else if (rx_run_left == 0) begin
			rx_ready_now = !rx_ready_now;
			rx_run_left  = rx_ready_now ? $urandom_range(1, 24) : $urandom_range(1, 8);
			result_ready <= rx_ready_now;
		end else begin
			rx_run_left--;
		end
	end

	initial begin
		int k;

		for (k = 0; k < NUM_SERVERS; k++)
			srv_free_pred[k] = '0;
		wait_total_pred = '0;
		long_tally_pred = '0;
		active_reg      = ACT_RESET;
		thresh_reg      = THR_RESET;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_wait_threshold();
		test_active_count();
		test_field_extremes();
		test_random_traffic();
		test_total_saturation();
		settle_block();

		if (mismatches == 0 && expected_assignments.size() == 0)
			$display("PASS earliest_free_server_assigner_unit");
		else
			$display("FAIL earliest_free_server_assigner_unit");
		$finish;
	end

	// Hard stop well past the slowest legal run.
	initial begin
		#4000000;
		$display("FAIL earliest_free_server_assigner_unit");
		$finish;
	end

endmodule
